FILE: rtl/prr_pkg.sv
// shared constants and types for the polyphase rational resampler
// no dependencies
package prr_pkg;
  localparam int MaxPhases = 32;
  localparam int MaxTaps = 64;
  localparam int SampleWidth = 16;
  localparam int CoefWidth = 16;
  localparam int PhaseW = 5;
  localparam int TapIdxW = 6;
  localparam int TapAddrW = PhaseW + TapIdxW;
  localparam int AccW = 48;
  localparam int ResultLimit = 32;
  localparam int SkipW = 10;
  localparam logic [SkipW-1:0] SkipMax = 10'd1023;

  localparam logic [1:0] RegInterp = 2'd0;
  localparam logic [1:0] RegDecim = 2'd1;
  localparam logic [1:0] RegTaps = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic shift;       // push the input sample into the delay line
    logic tap_wr;      // write the input tap
    logic clear;       // clear accumulators
    logic mac;         // multiply-accumulate step with registered operands
    logic [TapIdxW-1:0] k;  // tap index to fetch
    logic fetch;       // fetch operands for index k
    logic finish;      // load result register
  } dp_cmd_t;

  function automatic logic [SampleWidth-1:0] sat_round(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] s;
    logic signed [AccW-1:0] r;
    begin
      s = acc + AccW'(1 << (CoefWidth - 2));
      r = s >>> (CoefWidth - 1);
      if (r > AccW'(32767)) sat_round = 16'h7fff;
      else if (r < -AccW'(32768)) sat_round = 16'h8000;
      else sat_round = r[SampleWidth-1:0];
    end
  endfunction
endpackage

FILE: rtl/prr_datapath.sv
// delay line, tap memory and shared complex mac
// depends on prr_pkg
module prr_datapath (
  input  logic                               clk_i,
  input  prr_pkg::dp_cmd_t                   cmd_i,
  input  logic [prr_pkg::PhaseW-1:0]         phase_i,
  input  logic [prr_pkg::TapIdxW-1:0]        start_i,
  input  logic [prr_pkg::SampleWidth-1:0]    in_i_i,
  input  logic [prr_pkg::SampleWidth-1:0]    in_q_i,
  input  logic [prr_pkg::PhaseW-1:0]         wr_phase_i,
  input  logic [prr_pkg::TapIdxW-1:0]        wr_index_i,
  input  logic [prr_pkg::CoefWidth-1:0]      wr_value_i,
  input  logic                               rst_ni,
  output logic [prr_pkg::SampleWidth-1:0]    res_i_o,
  output logic [prr_pkg::SampleWidth-1:0]    res_q_o
);
  import prr_pkg::*;
  logic [SampleWidth-1:0] dl_i_q [MaxTaps];
  logic [SampleWidth-1:0] dl_q_q [MaxTaps];
  logic [CoefWidth-1:0] taps_q [MaxPhases*MaxTaps];
  logic signed [CoefWidth-1:0] coef_q;
  logic signed [SampleWidth-1:0] opi_q, opq_q;
  logic signed [SampleWidth+CoefWidth-1:0] prod_i, prod_q;
  logic signed [AccW-1:0] acc_i_q, acc_q_q;
  logic [TapIdxW-1:0] pos;
  logic [TapIdxW-1:0] wp_q;     // slot of the oldest sample, overwritten next
  logic [TapIdxW:0] fill_q;     // samples held since reset, saturates at MaxTaps
  logic [TapIdxW-1:0] raddr;
  logic pos_valid;

  // pos is the window position, 0 = oldest of the last MaxTaps samples
  assign pos = start_i + cmd_i.k;
  assign raddr = wp_q + pos;
  // positions never written since reset read as zero
  assign pos_valid = ({1'b0, pos} >= ((TapIdxW+1)'(MaxTaps) - fill_q));
  assign prod_i = opi_q * coef_q;
  assign prod_q = opq_q * coef_q;

  // circular delay line pointer and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      fill_q <= '0;
    end else if (cmd_i.shift) begin
      wp_q <= wp_q + 1'b1;
      if (fill_q != (TapIdxW+1)'(MaxTaps)) fill_q <= fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      dl_i_q[wp_q] <= in_i_i;
      dl_q_q[wp_q] <= in_q_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_wr) taps_q[{wr_phase_i, wr_index_i}] <= wr_value_i;
    if (cmd_i.fetch) begin
      coef_q <= taps_q[{phase_i, cmd_i.k}];
      opi_q <= pos_valid ? dl_i_q[raddr] : '0;
      opq_q <= pos_valid ? dl_q_q[raddr] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      acc_i_q <= '0;
      acc_q_q <= '0;
    end else if (cmd_i.mac) begin
      acc_i_q <= acc_i_q + AccW'(prod_i);
      acc_q_q <= acc_q_q + AccW'(prod_q);
    end
    if (cmd_i.finish) begin
      res_i_o <= sat_round(acc_i_q);
      res_q_o <= sat_round(acc_q_q);
    end
  end
endmodule

FILE: rtl/prr_ctrl.sv
// sequencer: phase and skip bookkeeping, mac loop and output handshake
// depends on prr_pkg
module prr_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_cmd_i,
  input  logic [5:0]                  interp_i,
  input  logic [10:0]                 decim_i,
  input  logic [6:0]                  ntaps_i,
  output prr_pkg::dp_cmd_t            cmd_o,
  output logic [prr_pkg::PhaseW-1:0]  phase_o,
  output logic [prr_pkg::TapIdxW-1:0] start_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        out_last_o
);
  import prr_pkg::*;
  localparam logic [2:0] SIdle = 3'd0, SFetch = 3'd1, SMac = 3'd2, SDrain = 3'd3,
                         SFin = 3'd4, SStep = 3'd5, SOut = 3'd6;
  logic [2:0] state_q, state_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [SkipW-1:0] skip_q, skip_d;
  logic [TapIdxW:0] k_q, k_d;
  logic [5:0] n_q, n_d;
  logic [11:0] p_q, p_d;       // phase sum being reduced
  logic [11:0] carry_q, carry_d;
  logic last_q, last_d;
  logic [5:0] interp;
  logic [6:0] ntaps;
  logic [10:0] decim;
  logic acc_in;

  assign interp = (interp_i == 6'd0) ? 6'd1 : (interp_i > 6'd32) ? 6'd32 : interp_i;
  assign decim = (decim_i == 11'd0) ? 11'd1 : decim_i;
  assign ntaps = (ntaps_i == 7'd0) ? 7'd1 : (ntaps_i > 7'd64) ? 7'd64 : ntaps_i;
  assign start_o = TapIdxW'(7'd64 - ntaps);
  assign phase_o = phase_q;
  assign in_ready_o = (state_q == SIdle);
  assign acc_in = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == SOut);
  assign out_last_o = last_q;

  always_comb begin
    state_d = state_q; phase_d = phase_q; skip_d = skip_q; k_d = k_q;
    n_d = n_q; p_d = p_q; carry_d = carry_q; last_d = last_q;
    cmd_o = '0;
    cmd_o.k = k_q[TapIdxW-1:0];
    case (state_q)
      SIdle: begin
        if (acc_in) begin
          if (in_cmd_i) begin
            cmd_o.tap_wr = 1'b1;
          end else begin
            cmd_o.shift = 1'b1;
            if (skip_q != '0) skip_d = skip_q - 1'b1;
            else begin
              n_d = '0;
              k_d = '0;
              state_d = SFetch;
            end
          end
        end
      end
      SFetch: begin
        cmd_o.clear = 1'b1;
        cmd_o.fetch = 1'b1;
        k_d = k_q + 1'b1;
        state_d = SMac;
      end
      // operands for k-1 are registered; fetch k while accumulating
      SMac: begin
        cmd_o.mac = 1'b1;
        if (k_q == {1'b0, ntaps[TapIdxW-1:0]} || k_q == 7'd64 && ntaps == 7'd64) begin
          state_d = SFin;
        end else begin
          cmd_o.fetch = 1'b1;
          k_d = k_q + 1'b1;
        end
      end
      SFin: begin
        cmd_o.finish = 1'b1;
        p_d = 12'(phase_q) + 12'(decim);
        carry_d = '0;
        state_d = SStep;
      end
      // repeated subtraction gives quotient and remainder
      SStep: begin
        if (p_q >= 12'(interp)) begin
          p_d = p_q - 12'(interp);
          carry_d = carry_q + 1'b1;
        end else begin
          phase_d = p_q[PhaseW-1:0];
          n_d = n_q + 1'b1;
          last_d = (carry_q != '0) || (n_q == 6'(ResultLimit - 1));
          if (carry_q == '0) skip_d = '0;
          else skip_d = (carry_q - 1'b1 > 12'(SkipMax)) ? SkipMax : SkipW'(carry_q - 1'b1);
          state_d = SOut;
        end
      end
      SOut: begin
        if (out_ready_i) begin
          k_d = '0;
          state_d = last_q ? SIdle : SFetch;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; phase_q <= '0; skip_q <= '0; k_q <= '0;
      n_q <= '0; p_q <= '0; carry_q <= '0; last_q <= 1'b0;
    end else begin
      state_q <= state_d; phase_q <= phase_d; skip_q <= skip_d; k_q <= k_d;
      n_q <= n_d; p_q <= p_d; carry_q <= carry_d; last_q <= last_d;
    end
  end
endmodule

FILE: rtl/polyphase_rational_resampler.sv
// polyphase rational resampler top level: config registers, controller, datapath
// depends on prr_pkg, prr_ctrl, prr_datapath
//
// input stream: tuser = cmd (0 sample, 1 tap write); tdata carries sample_i,
// sample_q, tap_phase, tap_index, tap_value. tap writes and skipped samples
// produce nothing and leave the input ready for the next item. a sample shifts
// into a 64-entry delay line; when not skipped it causes up to 32 results on
// the output stream, tdata = out_i, out_q and tlast = last of the run.
// each result is accumulated by the shared complex mac over the taps of its
// phase, then the phase is updated by repeated subtraction of interp, and the
// result is handed over. no new item is taken until the run is delivered.
// reset empties the delay line, clears phase and skip count and sets registers
// to interp 1, decim 1, taps 64; the tap memory must be written before use. a
// stalled receiver holds the result in place and the sequencer waits.
module polyphase_rational_resampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // sample_i, sample_q, tap_phase, tap_index, tap_value
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // out_i, out_q
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [10:0] cfg_wdata_i
);
  import prr_pkg::*;
  logic [5:0] interp_q;
  logic [10:0] decim_q;
  logic [6:0] ntaps_q;
  dp_cmd_t cmd;
  logic [PhaseW-1:0] phase;
  logic [TapIdxW-1:0] start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_q <= 6'd1; decim_q <= 11'd1; ntaps_q <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegInterp: interp_q <= cfg_wdata_i[5:0];
        RegDecim: decim_q <= cfg_wdata_i;
        RegTaps: ntaps_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  prr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_cmd_i(s_axis_tuser),
    .interp_i(interp_q), .decim_i(decim_q), .ntaps_i(ntaps_q),
    .cmd_o(cmd), .phase_o(phase), .start_o(start),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_last_o(m_axis_tlast)
  );

  prr_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .phase_i(phase), .start_i(start),
    .in_i_i(s_axis_tdata[15:0]), .in_q_i(s_axis_tdata[31:16]),
    .wr_phase_i(s_axis_tdata[36:32]), .wr_index_i(s_axis_tdata[42:37]),
    .wr_value_i(s_axis_tdata[58:43]),
    .res_i_o(m_axis_tdata[15:0]), .res_q_o(m_axis_tdata[31:16])
  );

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken during output");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
endmodule

FILE: bench/polyphase_rational_resampler_tb.sv
// self-checking bench for the polyphase rational resampler: bursty input stream,
// stalling output stream, register changes between phases, scoreboard prediction
// depends on prr_pkg and the polyphase_rational_resampler rtl
`timescale 1ns / 1ps

module polyphase_rational_resampler_tb;
  import prr_pkg::*;

  localparam int LatencyWait = 2400;
  localparam longint CycleLimit = 10000000;

  typedef struct {
    logic signed [15:0] out_i;
    logic signed [15:0] out_q;
    logic               last;
  } resampled_t;

  class resampler_scoreboard;
    logic signed [15:0] dline_i[MaxTaps];
    logic signed [15:0] dline_q[MaxTaps];
    logic signed [15:0] coef[MaxPhases][MaxTaps];
    bit written[MaxPhases][MaxTaps];
    int unsigned phase, skip;
    int unsigned interp_r, decim_r, ntaps_r;
    resampled_t pending[$];
    int errors, results, inputs;

    function new();
      foreach (dline_i[k]) begin
        dline_i[k] = '0;
        dline_q[k] = '0;
      end
      foreach (coef[p, k]) begin
        coef[p][k] = '0;
        written[p][k] = 1'b0;
      end
      phase = 0; skip = 0;
      interp_r = 1; decim_r = 1; ntaps_r = 64;
      errors = 0; results = 0; inputs = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [10:0] val);
      if (idx == RegInterp) interp_r = val[5:0];
      else if (idx == RegDecim) decim_r = val;
      else if (idx == RegTaps) ntaps_r = val[6:0];
    endfunction

    function logic signed [15:0] round_sat(longint acc);
      longint r;
      r = (acc + 64'sd16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
    endfunction

    function void note_input(logic cmd, logic signed [15:0] si, logic signed [15:0] sq,
                             logic [4:0] tp, logic [5:0] ti, logic signed [15:0] tv);
      int unsigned interp, decim, ntaps, carry, n, p, start;
      longint acc_i, acc_q;
      resampled_t r;
      inputs++;
      if (cmd) begin
        coef[tp][ti] = tv;
        written[tp][ti] = 1'b1;
        return;
      end
      for (int k = 0; k < MaxTaps - 1; k++) begin
        dline_i[k] = dline_i[k+1];
        dline_q[k] = dline_q[k+1];
      end
      dline_i[MaxTaps-1] = si;
      dline_q[MaxTaps-1] = sq;
      if (skip != 0) begin
        skip--;
        return;
      end
      interp = (interp_r == 0) ? 1 : (interp_r > MaxPhases ? MaxPhases : interp_r);
      decim = (decim_r == 0) ? 1 : decim_r;
      ntaps = (ntaps_r == 0) ? 1 : (ntaps_r > MaxTaps ? MaxTaps : ntaps_r);
      start = MaxTaps - ntaps;
      carry = 0;
      n = 0;
      while (carry == 0 && n < ResultLimit) begin
        acc_i = 0;
        acc_q = 0;
        for (int k = 0; k < ntaps; k++) begin
          acc_i += longint'(dline_i[start+k]) * longint'(coef[phase % MaxPhases][k]);
          acc_q += longint'(dline_q[start+k]) * longint'(coef[phase % MaxPhases][k]);
        end
        r.out_i = round_sat(acc_i);
        r.out_q = round_sat(acc_q);
        r.last = 1'b0;
        pending.push_back(r);
        n++;
        p = phase + decim;
        carry = p / interp;
        phase = (p % interp) & 31;
      end
      pending[pending.size()-1].last = 1'b1;
      skip = (carry == 0) ? 0 : ((carry - 1 > 1023) ? 1023 : carry - 1);
    endfunction

    function void check(logic signed [15:0] oi, logic signed [15:0] oq, logic last);
      resampled_t e;
      results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result i=%0d q=%0d last=%0b", $time, oi, oq, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.out_i !== oi || e.out_q !== oq || e.last !== last) begin
        $display("%0t: mismatch expected i=%0d q=%0d last=%0b actual i=%0d q=%0d last=%0b",
                 $time, e.out_i, e.out_q, e.last, oi, oq, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = '0;
  logic [10:0] cfg_wdata_i = '0;

  resampler_scoreboard sb = new();
  longint cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  bit failed = 0;

  polyphase_rational_resampler dut (.*);

  always #5 clk_i = ~clk_i;

  // output side: check every accepted result, then pick next ready
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check(m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tlast);
    if (cycles % 97 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // called right after a rising edge; returns at the edge that takes the item
  task automatic send(logic cmd, logic [15:0] si, logic [15:0] sq,
                      logic [4:0] tp, logic [5:0] ti, logic [15:0] tv);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {5'b0, tv, ti, tp, sq, si};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(cmd, si, sq, tp, ti, tv);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LatencyWait) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [10:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic logic [15:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // write every tap the current settings can read that has no value yet
  task automatic cover_taps();
    int interp, ntaps;
    interp = (sb.interp_r == 0) ? 1 : (sb.interp_r > MaxPhases ? MaxPhases : sb.interp_r);
    ntaps = (sb.ntaps_r == 0) ? 1 : (sb.ntaps_r > MaxTaps ? MaxTaps : sb.ntaps_r);
    for (int p = 0; p < MaxPhases; p++)
      if (p < interp || p == sb.phase)
        for (int k = 0; k < ntaps; k++)
          if (!sb.written[p][k])
            send(1'b1, 16'h0, 16'h0, p[4:0], k[5:0], rand_val());
  endtask

  task automatic random_phase(int n_items);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 9) < 2)
        send(1'b1, 16'($urandom), 16'($urandom), 5'($urandom), 6'($urandom), rand_val());
      else
        send(1'b0, rand_val(), rand_val(), 5'($urandom), 6'($urandom), 16'($urandom));
    end
    drain();
  endtask

  initial begin
    // interp, decim, taps per phase for each random phase
    int cfgs[9][3] = '{'{3, 2, 8}, '{32, 1, 2}, '{0, 0, 0}, '{63, 2047, 2},
                       '{5, 7, 6}, '{2, 3, 1}, '{1, 2047, 127}, '{32, 31, 3},
                       '{1, 1, 64}};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every tap the reset settings read gets written first
    cover_taps();

    // directed: reset settings, then saturation with two taps
    send(1'b0, 16'h7fff, 16'h8000, 5'd0, 6'd0, 16'h0);
    send(1'b0, 16'h8000, 16'h7fff, 5'd31, 6'd63, 16'hffff);
    drain();
    write_cfg(RegTaps, 11'd2);
    send(1'b1, 16'h0, 16'h0, 5'd0, 6'd0, 16'h8000);
    send(1'b1, 16'h0, 16'h0, 5'd0, 6'd1, 16'h8000);
    repeat (3) send(1'b0, 16'h8000, 16'h8000, 5'd0, 6'd0, 16'h0);
    repeat (3) send(1'b0, 16'h7fff, 16'h7fff, 5'd0, 6'd0, 16'h0);
    send(1'b0, 16'h0001, 16'hffff, 5'd0, 6'd0, 16'h0);
    send(1'b1, 16'hffff, 16'hffff, 5'd0, 6'd0, 16'h7fff);
    send(1'b1, 16'hffff, 16'hffff, 5'd0, 6'd1, 16'h7fff);
    repeat (2) send(1'b0, 16'h7fff, 16'h8000, 5'd0, 6'd0, 16'h0);
    send(1'b0, 16'h0000, 16'h0000, 5'd0, 6'd0, 16'h0);
    send(1'b1, 16'hffff, 16'hffff, 5'd31, 6'd63, 16'h8000);
    send(1'b1, 16'h0000, 16'h0000, 5'd31, 6'd0, 16'h0001);
    drain();

    foreach (cfgs[c]) begin
      write_cfg(RegInterp, 11'(cfgs[c][0]));
      write_cfg(RegDecim, 11'(cfgs[c][1]));
      write_cfg(RegTaps, 11'(cfgs[c][2]));
      cover_taps();
      random_phase(20);
    end

    $display("covered %0d input items, %0d results, reset settings and 9 more incl. extremes",
             sb.inputs, sb.results);
    $display("with bursty input and random output stalls; %0d mismatches", sb.errors);
    failed = (sb.errors != 0) || (sb.pending.size() != 0);
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
